// ===== design/circular_queue_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Circular queue assertion macros
// Shorthand for clocked implication checks with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_QUEUE_UNIT_MACROS_SVH
`define CIRCULAR_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define CQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/cq_pkg.sv =====
// ----------------------------------------------------------------------------
// Circular queue package
// Widths, operation and status codes, and the control/status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package cq_pkg;

   localparam int WORD_W            = 32;
   localparam int FUNC_W            = 2;
   localparam int STAT_W            = 2;
   localparam int CAP_W             = 7;
   localparam int CAP_CMP_W         = 13;   // holds any depth up to 4096
   localparam int MAX_DEPTH_DEFAULT = 64;
   localparam int CAP_RESET         = 64;

   // Operation codes
   localparam logic [FUNC_W-1:0] FUNC_ENQ  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DEQ  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DISP = 2'd2;

   // Result status codes
   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

   // Controller to datapath
   typedef struct packed {
      logic load;        // latch request, point cursor at head
      logic enq;         // commit enqueue, load result
      logic deq;         // commit dequeue, load result
      logic disp_step;   // emit word at cursor, advance cursor
      logic disp_empty;  // emit empty status
   } cq_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              empty;
      logic              cur_is_tail;
   } cq_stat_type;

endpackage

// ===== design/cq_dpath.sv =====
// ----------------------------------------------------------------------------
// Circular queue datapath
// Ring storage with one registered read port, head/tail/cursor pointers,
// capacity register and the result payload registers.
// ----------------------------------------------------------------------------
module cq_dpath #(
   parameter int MAX_DEPTH = cq_pkg::MAX_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cq_pkg::cq_cmd_type                  cmd,
   output cq_pkg::cq_stat_type                 stat,
   input  logic        [cq_pkg::FUNC_W-1:0]    req_func,
   input  logic signed [cq_pkg::WORD_W-1:0]    req_item,
   input  logic                                csr_wr_en,
   input  logic        [cq_pkg::CAP_W-1:0]     csr_wr_data,
   output logic        [cq_pkg::STAT_W-1:0]    rsp_status,
   output logic signed [cq_pkg::WORD_W-1:0]    rsp_value,
   output logic                                rsp_last
);

   localparam int PTR_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int CAP_LIMIT = (cq_pkg::CAP_RESET > MAX_DEPTH) ? MAX_DEPTH
                                                             : cq_pkg::CAP_RESET;
   localparam logic [PTR_W-1:0] RST_LAST = PTR_W'(CAP_LIMIT - 1);
   localparam logic [PTR_W-1:0] MAX_LAST = PTR_W'(MAX_DEPTH - 1);

   // Step an index around the ring, wrapping after the last usable entry
   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] idx,
                                                 input logic [PTR_W-1:0] lim);
      return (idx == lim) ? '0 : idx + PTR_W'(1);
   endfunction

   logic signed [cq_pkg::WORD_W-1:0] storage_mem [MAX_DEPTH];

   logic        [PTR_W-1:0]          head_ff, head_in;
   logic        [PTR_W-1:0]          tail_ff, tail_in;
   logic        [PTR_W-1:0]          cur_ff, cur_in;
   logic        [PTR_W-1:0]          last_ff, last_in;
   logic                             empty_ff, empty_in;
   logic        [cq_pkg::FUNC_W-1:0] func_ff, func_in;
   logic signed [cq_pkg::WORD_W-1:0] item_ff, item_in;
   logic signed [cq_pkg::WORD_W-1:0] rd_data_ff;
   logic        [cq_pkg::STAT_W-1:0] status_ff, status_in;
   logic signed [cq_pkg::WORD_W-1:0] value_ff, value_in;
   logic                             last_out_ff, last_out_in;

   logic        [PTR_W-1:0]          head_nxt, tail_nxt, cur_nxt;
   logic        [PTR_W-1:0]          rd_addr, wr_addr;
   logic                             wr_en;
   logic signed [cq_pkg::WORD_W-1:0] wr_data;
   logic        [cq_pkg::CAP_CMP_W-1:0] cap_wide;
   logic        [PTR_W-1:0]          cap_last;

   assign head_nxt = wrap_inc(head_ff, last_ff);
   assign tail_nxt = wrap_inc(tail_ff, last_ff);
   assign cur_nxt  = wrap_inc(cur_ff, last_ff);

   // Clamp a capacity write to 1..MAX_DEPTH and keep it as the last index
   always_comb begin
      cap_wide = cq_pkg::CAP_CMP_W'(csr_wr_data);
      if (cap_wide > cq_pkg::CAP_CMP_W'(MAX_DEPTH)) begin
         cap_last = MAX_LAST;
      end else if (csr_wr_data == '0) begin
         cap_last = '0;
      end else begin
         cap_last = PTR_W'(cap_wide - cq_pkg::CAP_CMP_W'(1));
      end
   end

   // Next state of pointers, storage write and result payload
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      cur_in      = cur_ff;
      last_in     = last_ff;
      empty_in    = empty_ff;
      func_in     = func_ff;
      item_in     = item_ff;
      status_in   = status_ff;
      value_in    = value_ff;
      last_out_in = last_out_ff;
      rd_addr     = cur_ff;
      wr_en       = 1'b0;
      wr_addr     = tail_nxt;
      wr_data     = item_ff;

      // Latch the request and start reading at the head
      if (cmd.load) begin
         func_in = req_func;
         item_in = req_item;
         cur_in  = head_ff;
         rd_addr = head_ff;
      end

      // Store at the tail, or report a full queue
      if (cmd.enq) begin
         value_in    = '0;
         last_out_in = 1'b1;
         status_in   = cq_pkg::ST_OK;
         if (empty_ff) begin
            head_in  = '0;
            tail_in  = '0;
            empty_in = 1'b0;
            wr_en    = 1'b1;
            wr_addr  = '0;
         end else if (tail_nxt == head_ff) begin
            status_in = cq_pkg::ST_OVERFLOW;
         end else begin
            tail_in = tail_nxt;
            wr_en   = 1'b1;
         end
      end

      // Remove the head word, or report an empty queue
      if (cmd.deq) begin
         last_out_in = 1'b1;
         if (empty_ff) begin
            status_in = cq_pkg::ST_UNDERFLOW;
            value_in  = '0;
         end else begin
            status_in = cq_pkg::ST_OK;
            value_in  = rd_data_ff;
            if (head_ff == tail_ff) begin
               head_in  = '0;
               tail_in  = '0;
               empty_in = 1'b1;
            end else begin
               head_in = head_nxt;
            end
         end
      end

      // Listing on an empty queue gives one status result
      if (cmd.disp_empty) begin
         status_in   = cq_pkg::ST_EMPTY;
         value_in    = '0;
         last_out_in = 1'b1;
      end

      // Emit the word under the cursor and read ahead at the next entry
      if (cmd.disp_step) begin
         status_in   = cq_pkg::ST_OK;
         value_in    = rd_data_ff;
         last_out_in = (cur_ff == tail_ff);
         cur_in      = cur_nxt;
         rd_addr     = cur_nxt;
      end

      // Take a new capacity only while the queue is empty
      if (csr_wr_en && empty_ff) begin
         last_in = cap_last;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
         last_ff  <= RST_LAST;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
         last_ff  <= last_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      func_ff     <= func_in;
      item_ff     <= item_in;
      status_ff   <= status_in;
      value_ff    <= value_in;
      last_out_ff <= last_out_in;
   end

   // Ring storage: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         storage_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= storage_mem[rd_addr];
   end

   assign stat.func        = func_ff;
   assign stat.empty       = empty_ff;
   assign stat.cur_is_tail = (cur_ff == tail_ff);

   assign rsp_status = status_ff;
   assign rsp_value  = value_ff;
   assign rsp_last   = last_out_ff;

endmodule

// ===== design/cq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Circular queue controller
// Accepts one request at a time, sequences the datapath and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module cq_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [cq_pkg::FUNC_W-1:0]      req_func,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  cq_pkg::cq_stat_type            stat,
   output cq_pkg::cq_cmd_type             cmd
);

   typedef enum logic {
      S_IDLE,
      S_BUSY
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;
   logic      emit;

   // Result register can take a new item when empty or draining
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Decode the next step
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_func == cq_pkg::FUNC_ENQ || req_func == cq_pkg::FUNC_DEQ ||
                   req_func == cq_pkg::FUNC_DISP) begin
                  cmd.load = 1'b1;
                  state_in = S_BUSY;
               end
            end
         end
         S_BUSY: begin
            if (slot_free) begin
               unique case (stat.func)
                  cq_pkg::FUNC_ENQ: begin
                     cmd.enq  = 1'b1;
                     state_in = S_IDLE;
                  end
                  cq_pkg::FUNC_DEQ: begin
                     cmd.deq  = 1'b1;
                     state_in = S_IDLE;
                  end
                  cq_pkg::FUNC_DISP: begin
                     if (stat.empty) begin
                        cmd.disp_empty = 1'b1;
                        state_in       = S_IDLE;
                     end else begin
                        cmd.disp_step = 1'b1;
                        if (stat.cur_is_tail) begin
                           state_in = S_IDLE;
                        end
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign emit = cmd.enq || cmd.deq || cmd.disp_step || cmd.disp_empty;

   // Hold the result valid until taken, set it when a result is loaded
   always_comb begin
      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/circular_queue_unit.sv =====
// ----------------------------------------------------------------------------
// Circular queue unit
// Ring-buffer queue of signed words with a run-time capacity (1 to
// MAX_DEPTH, reset 64, written only while the queue is empty). One item
// is taken at a time: enqueue and dequeue are accepted, then committed
// into the result register; an unknown operation is dropped at accept
// with no result; a listing of N stored words gives one word per cycle
// from the storage's registered read port while no result waits.
// A waiting result only stalls the commit, not the accept of the next
// item. Storage needs no clearing after reset; the unit is ready at once.
// ----------------------------------------------------------------------------
module circular_queue_unit #(
   parameter int MAX_DEPTH = cq_pkg::MAX_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic        [cq_pkg::FUNC_W-1:0]    req_func,
   input  logic signed [cq_pkg::WORD_W-1:0]    req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic        [cq_pkg::STAT_W-1:0]    rsp_status,
   output logic signed [cq_pkg::WORD_W-1:0]    rsp_value,
   output logic                                rsp_last,
   input  logic                                csr_wr_en,
   input  logic        [cq_pkg::CAP_W-1:0]     csr_wr_data
);

   cq_pkg::cq_cmd_type  cmd;
   cq_pkg::cq_stat_type stat;

   // Sequencer
   cq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Storage, pointers and result payload
   cq_dpath #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_func    (req_func),
      .req_item    (req_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_status  (rsp_status),
      .rsp_value   (rsp_value),
      .rsp_last    (rsp_last)
   );

endmodule

// ===== design/cq_checker.sv =====
// ----------------------------------------------------------------------------
// Circular queue port checker
// Watches the unit's ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`include "circular_queue_unit_macros.svh"

module cq_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic        [cq_pkg::FUNC_W-1:0]    req_func,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic        [cq_pkg::STAT_W-1:0]    rsp_status,
   input logic signed [cq_pkg::WORD_W-1:0]    rsp_value,
   input logic                                rsp_last
);

   // A stalled result holds
   `CQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_value) && $stable(rsp_last), "stalled result changed")

   // An enqueue keeps the unit busy for its commit cycle
   `CQ_ASSERT_NEXT(a_enq_busy, clock, reset, req_valid && req_ready && req_func == cq_pkg::FUNC_ENQ, !req_ready, "ready right after enqueue accept")

   // An unknown operation is dropped at once
   `CQ_ASSERT_NEXT(a_nop_free, clock, reset, req_valid && req_ready && req_func != cq_pkg::FUNC_ENQ && req_func != cq_pkg::FUNC_DEQ && req_func != cq_pkg::FUNC_DISP, req_ready, "unknown operation stalled the unit")

   // A listing runs without gaps until its last word
   `CQ_ASSERT_NEXT(a_list_cont, clock, reset, rsp_valid && rsp_ready && !rsp_last, rsp_valid, "gap inside a listing")

   // No new item while a listing is still open
   `CQ_ASSERT_IMPLY(a_list_busy, clock, reset, rsp_valid && !rsp_last, !req_ready, "accepting during a listing")

endmodule

bind circular_queue_unit cq_checker u_cq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .req_func   (req_func),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_status (rsp_status),
   .rsp_value  (rsp_value),
   .rsp_last   (rsp_last)
);
